// ----- sv/array_list_insert_delete_defines.svh -----
// Assertion macros for the packed list block.
// ALI_ASSERT samples on the clock and ignores cycles in reset.
// ALI_ASSERT_RST samples on the clock at all times, reset included.
`ifndef ARRAY_LIST_INSERT_DELETE_DEFINES_SVH
`define ARRAY_LIST_INSERT_DELETE_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define ALI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define ALI_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ALI_ASSERT(lbl, prop, msg)
`define ALI_ASSERT_RST(lbl, prop, msg)
`endif

`endif

// ----- sv/ali_pkg.sv -----
package ali_pkg;

	// widest index or count for any list depth up to 256
	localparam int IDX_W = 9;
	localparam int VAL_W = 64;

	// request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_DELETE = 2'd1;
	localparam logic [1:0] REQ_REMOVE = 2'd2;
	localparam logic [1:0] REQ_READ   = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	// what every cell does on a clock
	typedef enum logic [1:0] {
		SH_HOLD,
		SH_INS,
		SH_DEL,
		SH_ROT
	} ali_shift_t;

	// broadcast to the whole row of cells
	typedef struct packed {
		ali_shift_t        op;
		logic [IDX_W-1:0]  pos;
		logic [IDX_W-1:0]  len;
		logic              keep;
		logic [VAL_W-1:0]  ins_val;
		logic [VAL_W-1:0]  head;
	} ali_ctrl_t;

endpackage

// ----- sv/array_list_insert_delete.sv -----
// Packed list of up to DEPTH signed 64-bit entries, kept in a row of cells,
// one entry per cell, with a live-entry count. One request is taken at a
// time; its one result is held in an output register, so the next request
// may be taken while that result still waits. Insert and delete shift the
// cells at and above the position by one place in parallel in the cycle the
// request is taken; the sequencer then passes through its done state, which
// writes the result to the output register. Remove-all and an in-range read
// rotate the list through the head cell, one entry a cycle, count times,
// dropping matches or picking out the entry at the position, and then pass
// through the done state. A rejected request changes nothing and goes
// straight to the done state, like an insert. A result that is not taken
// holds the sequencer once the following request is done, and so stalls the
// input. The storage is not cleared at reset; entries at or above the count
// are never read. Position, removed_count and entry_count are 5 bits wide;
// for a DEPTH above 31 the counts on the output are their low 5 bits.
`include "array_list_insert_delete_defines.svh"

module array_list_insert_delete #(
	parameter int DEPTH = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  req_type,
	input  logic [4:0]  position,
	input  logic signed [63:0] value,

	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [4:0]  removed_count,
	output logic [4:0]  entry_count,
	output logic signed [63:0] read_value
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = ali_pkg::IDX_W;
	localparam int VW = ali_pkg::VAL_W;
	localparam logic [IW-1:0] DEPTH_I = IW'(DEPTH);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DONE
	} state_t;

	state_t            state_q;
	logic [CW-1:0]     count_q;
	logic [CW-1:0]     steps_q;    // rotations still to do
	logic [CW-1:0]     len_q;      // live length during a rotation
	logic [CW-1:0]     idx_q;      // original index of the current head
	logic [CW-1:0]     rem_q;
	logic [VW-1:0]     rd_q;
	logic [1:0]        res_st_q;
	logic [1:0]        mode_q;
	logic [4:0]        pos_q;
	logic [VW-1:0]     val_q;

	logic              out_valid_q;
	logic [1:0]        out_st_q;
	logic [4:0]        out_rem_q;
	logic [4:0]        out_cnt_q;
	logic [VW-1:0]     out_rd_q;

	logic [VW-1:0]     ent [DEPTH];
	ali_pkg::ali_ctrl_t ctrl;

	logic              accept;
	logic [IW-1:0]     pos_i;
	logic [IW-1:0]     count_i;
	logic              ins_ok;
	logic              pos_lt_count;
	logic              step;
	logic              keep;

	assign accept       = in_valid && in_ready;
	assign in_ready     = (state_q == S_IDLE);
	assign pos_i        = IW'(position);
	assign count_i      = IW'(count_q);
	assign ins_ok       = (pos_i <= count_i) && (count_i < DEPTH_I);
	assign pos_lt_count = (pos_i < count_i);
	assign step         = (state_q == S_SCAN) && (steps_q != '0);
	// drop the head only when removing and it matches on all 64 bits
	assign keep         = !((mode_q == ali_pkg::REQ_REMOVE) && (ent[0] == val_q));

	// drive the row of cells
	always_comb begin
		ctrl.op      = ali_pkg::SH_HOLD;
		ctrl.pos     = pos_i;
		ctrl.len     = count_i;
		ctrl.keep    = keep;
		ctrl.ins_val = value;
		ctrl.head    = ent[0];
		if (accept && req_type == ali_pkg::REQ_INSERT && ins_ok) begin
			ctrl.op = ali_pkg::SH_INS;
		end else if (accept && req_type == ali_pkg::REQ_DELETE && pos_lt_count) begin
			ctrl.op = ali_pkg::SH_DEL;
		end else if (step) begin
			ctrl.op  = ali_pkg::SH_ROT;
			ctrl.len = IW'(len_q);
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [VW-1:0] left_d;
		logic [VW-1:0] right_d;
		if (g == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_left
			assign left_d = ent[g-1];
		end
		if (g == DEPTH - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_right
			assign right_d = ent[g+1];
		end
		ali_cell #(.INDEX(g)) u_cell (
			.clk   (clk),
			.ctrl  (ctrl),
			.left  (left_d),
			.right (right_d),
			.data  (ent[g])
		);
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// drop the offered result once it is taken, unless a new one replaces it
			if (out_valid_q && out_ready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						mode_q   <= req_type;
						pos_q    <= position;
						val_q    <= value;
						rem_q    <= '0;
						rd_q     <= '0;
						steps_q  <= count_q;
						len_q    <= count_q;
						idx_q    <= '0;
						unique case (req_type)
							ali_pkg::REQ_INSERT: begin
								state_q <= S_DONE;
								if (pos_i > count_i) begin
									res_st_q <= ali_pkg::ST_RANGE;
								end else if (!ins_ok) begin
									res_st_q <= ali_pkg::ST_FULL;
								end else begin
									res_st_q <= ali_pkg::ST_OK;
									count_q  <= count_q + CW'(1);
								end
							end
							ali_pkg::REQ_DELETE: begin
								state_q <= S_DONE;
								if (!pos_lt_count) begin
									res_st_q <= ali_pkg::ST_RANGE;
								end else begin
									res_st_q <= ali_pkg::ST_OK;
									count_q  <= count_q - CW'(1);
								end
							end
							ali_pkg::REQ_REMOVE: begin
								res_st_q <= ali_pkg::ST_OK;
								state_q  <= S_SCAN;
							end
							default: begin
								if (!pos_lt_count) begin
									res_st_q <= ali_pkg::ST_RANGE;
									state_q  <= S_DONE;
								end else begin
									res_st_q <= ali_pkg::ST_OK;
									state_q  <= S_SCAN;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (step) begin
						if (!keep) begin
							len_q <= len_q - CW'(1);
							rem_q <= rem_q + CW'(1);
						end
						if (mode_q == ali_pkg::REQ_READ && IW'(idx_q) == IW'(pos_q)) begin
							rd_q <= ent[0];
						end
						steps_q <= steps_q - CW'(1);
						idx_q   <= idx_q + CW'(1);
					end else begin
						count_q <= len_q;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_st_q    <= res_st_q;
						out_rem_q   <= 5'(rem_q);
						out_cnt_q   <= 5'(count_q);
						out_rd_q    <= rd_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = out_st_q;
	assign removed_count = out_rem_q;
	assign entry_count   = out_cnt_q;
	assign read_value    = out_rd_q;

	`ALI_ASSERT(a_count_max, (IW'(count_q) <= DEPTH_I), "entry count above depth")
	`ALI_ASSERT(a_scan_sum, (state_q == S_SCAN) |-> (({1'b0, rem_q} + {1'b0, len_q}) == {1'b0, count_q}), "removed plus live differs from count during scan")
	`ALI_ASSERT(a_ins_grow, (accept && req_type == ali_pkg::REQ_INSERT && ins_ok) |=> (count_q == $past(count_q) + CW'(1)), "insert did not grow the list")
	`ALI_ASSERT_RST(a_rst_quiet, (!arst_n ##1 !arst_n) |-> (!out_valid && in_ready), "result offered or busy in reset")

endmodule

// ----- sv/ali_cell.sv -----
module ali_cell #(
	parameter int INDEX = 0
) (
	input  logic                      clk,
	input  ali_pkg::ali_ctrl_t        ctrl,
	input  logic [ali_pkg::VAL_W-1:0] left,
	input  logic [ali_pkg::VAL_W-1:0] right,
	output logic [ali_pkg::VAL_W-1:0] data
);

	localparam logic [ali_pkg::IDX_W-1:0] IDX = ali_pkg::IDX_W'(INDEX);
	localparam logic [ali_pkg::IDX_W-1:0] IDX_NEXT = ali_pkg::IDX_W'(INDEX + 1);

	logic [ali_pkg::VAL_W-1:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			ali_pkg::SH_INS: begin
				// take the new value at the slot, move up from below past it
				if (IDX == ctrl.pos) begin
					data_q <= ctrl.ins_val;
				end else if (IDX > ctrl.pos && IDX <= ctrl.len) begin
					data_q <= left;
				end
			end
			ali_pkg::SH_DEL: begin
				if (IDX >= ctrl.pos && IDX_NEXT < ctrl.len) begin
					data_q <= right;
				end
			end
			ali_pkg::SH_ROT: begin
				// advance toward the head; the tail slot takes a kept head
				if (IDX_NEXT < ctrl.len) begin
					data_q <= right;
				end else if (IDX_NEXT == ctrl.len && ctrl.keep) begin
					data_q <= ctrl.head;
				end
			end
			default: begin
				data_q <= data_q;
			end
		endcase
	end

	assign data = data_q;

endmodule
